[rtl/core/mtk_pkg.sv]
// shared types, codes and keypad character tables for the multi-tap text entry unit
package mtk_pkg;

    // item kinds
    localparam logic [2:0] FUNC_PRESS      = 3'd0;
    localparam logic [2:0] FUNC_LONG_PRESS = 3'd1;
    localparam logic [2:0] FUNC_TICK       = 3'd2;
    localparam logic [2:0] FUNC_COMMIT     = 3'd3;
    localparam logic [2:0] FUNC_START      = 3'd4;

    // special keys
    localparam logic [3:0] KEY_MODE     = 4'd10;
    localparam logic [3:0] KEY_FUNC     = 4'd11;
    localparam logic [3:0] KEY_BACK     = 4'd12;
    localparam logic [3:0] KEY_LAST_DIG = 4'd9;

    // entry modes
    localparam logic [1:0] MODE_UPPER  = 2'd0;
    localparam logic [1:0] MODE_LOWER  = 2'd1;
    localparam logic [1:0] MODE_DIGITS = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // configuration register indexes
    localparam logic CFG_MAX_LENGTH   = 1'b0;
    localparam logic CFG_COMMIT_TICKS = 1'b1;

    localparam logic [7:0] MAX_LENGTH_RST   = 8'd32;
    localparam logic [7:0] COMMIT_TICKS_RST = 8'd80;
    localparam logic [7:0] TICKS_SAT        = 8'd255;
    localparam logic [6:0] CHAR_ZERO        = 7'h30;

    typedef struct packed {
        logic [7:0] length_count;
        logic [1:0] entry_mode;
        logic       upper_flag;
        logic       pending_flag;
        logic [3:0] tap_key;
        logic [2:0] cycle_position;
        logic [7:0] idle_ticks;
    } state_t;

    typedef struct packed {
        logic       accepted;
        logic       write_valid;
        logic [7:0] write_index;
        logic [6:0] write_char;
        logic [7:0] text_length;
        logic [1:0] entry_mode_out;
        logic       pending_out;
    } result_t;

    // number of characters on a digit key
    function automatic logic [2:0] key_count(input logic [3:0] key);
        logic [2:0] cnt;
        unique case (key)
            4'd0:                cnt = 3'd2;
            4'd1, 4'd7, 4'd9:    cnt = 3'd5;
            default:             cnt = 3'd4;
        endcase
        return cnt;
    endfunction

    // character at a position of a digit key's cycle (upper case)
    function automatic logic [6:0] key_char(input logic [3:0] key, input logic [2:0] pos);
        logic [6:0] c;
        c = 7'h00;
        unique case (key)
            4'd0: begin
                unique case (pos)
                    3'd0:    c = 7'h20;
                    3'd1:    c = 7'h30;
                    default: c = 7'h00;
                endcase
            end
            4'd1: begin
                unique case (pos)
                    3'd0:    c = 7'h2E;
                    3'd1:    c = 7'h2C;
                    3'd2:    c = 7'h3F;
                    3'd3:    c = 7'h21;
                    3'd4:    c = 7'h31;
                    default: c = 7'h00;
                endcase
            end
            4'd7: begin
                unique case (pos)
                    3'd0:    c = 7'h50;
                    3'd1:    c = 7'h51;
                    3'd2:    c = 7'h52;
                    3'd3:    c = 7'h53;
                    3'd4:    c = 7'h37;
                    default: c = 7'h00;
                endcase
            end
            4'd8: begin
                unique case (pos)
                    3'd0:    c = 7'h54;
                    3'd1:    c = 7'h55;
                    3'd2:    c = 7'h56;
                    3'd3:    c = 7'h38;
                    default: c = 7'h00;
                endcase
            end
            4'd9: begin
                unique case (pos)
                    3'd0:    c = 7'h57;
                    3'd1:    c = 7'h58;
                    3'd2:    c = 7'h59;
                    3'd3:    c = 7'h5A;
                    3'd4:    c = 7'h39;
                    default: c = 7'h00;
                endcase
            end
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6: begin
                // three consecutive letters starting at A + 3*(key-2), then the digit
                if (pos < 3'd3) begin
                    c = 7'h41 + 7'(3 * (key - 4'd2)) + 7'(pos);
                end else if (pos == 3'd3) begin
                    c = CHAR_ZERO + 7'(key);
                end else begin
                    c = 7'h00;
                end
            end
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/multitap_keypad_text_entry_unit.sv]
// top level of the multi-tap keypad text entry unit
//
// Phone-keypad multi-tap text entry. Each input word is one event: key press,
// long press, timer tick, commit or start (kind in s_axis_tuser, key code in
// s_axis_tdata). Every accepted word produces exactly one result word that
// reports whether the event was handled, at most one character write (index
// and ASCII value, 0 for a deletion), the text length, the entry mode and the
// pending flag. The unit holds no text itself; the consumer applies the writes.
// Throughput is one word per clock unless the consumer stalls: the event is
// decoded and the state updated combinationally, straight into the output
// register that drives m_axis_tvalid. The output register frees in the same
// cycle it is taken, so back-pressure only stalls the input while a result is
// held. Configuration (max_length at index 0, commit_ticks at index 1) is
// written through cfg_wr_en/cfg_addr/cfg_wdata and must only change while no
// result is outstanding. Start clears the text to empty; the unit is ready
// right after reset.
module multitap_keypad_text_entry_unit (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,

    // event input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] key_code, [7:4] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] func

    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] write_index, [14:8] write_char,
                                        // [22:15] text_length, [24:23] entry_mode_out,
                                        // [25] pending_out, [31:26] zero
    output logic [1:0]  m_axis_tuser    // [0] accepted, [1] write_valid
);
    import mtk_pkg::*;

    // control and config registers
    state_t     state_reg;
    state_t     state_next;
    logic [7:0] max_length_reg;
    logic [7:0] commit_ticks_reg;
    logic       m_valid_reg;

    // output payload
    result_t    result_reg;
    result_t    result_next;

    logic       in_accept;

    // input is free whenever the output slot is empty or being drained
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    mtk_step u_step (
        .state        (state_reg),
        .func         (s_axis_tuser),
        .key_code     (s_axis_tdata[3:0]),
        .max_length   (max_length_reg),
        .commit_ticks (commit_ticks_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    // state, config and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.length_count   <= 8'd0;
            state_reg.entry_mode     <= MODE_UPPER;
            state_reg.upper_flag     <= 1'b1;
            state_reg.pending_flag   <= 1'b0;
            state_reg.tap_key        <= 4'd0;
            state_reg.cycle_position <= 3'd0;
            state_reg.idle_ticks     <= 8'd0;
            max_length_reg           <= MAX_LENGTH_RST;
            commit_ticks_reg         <= COMMIT_TICKS_RST;
            m_valid_reg              <= 1'b0;
        end else begin
            if (in_accept) begin
                state_reg <= state_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_MAX_LENGTH:   max_length_reg   <= cfg_wdata;
                    CFG_COMMIT_TICKS: commit_ticks_reg <= cfg_wdata;
                    default:          max_length_reg   <= max_length_reg;
                endcase
            end
            if (in_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on every accepted word
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0,
                            result_reg.pending_out,
                            result_reg.entry_mode_out,
                            result_reg.text_length,
                            result_reg.write_char,
                            result_reg.write_index};
    assign m_axis_tuser  = {result_reg.write_valid, result_reg.accepted};

endmodule

[rtl/core/mtk_step.sv]
// next-state and result logic for one keypad word
module mtk_step (
    input  mtk_pkg::state_t  state,
    input  logic [2:0]       func,
    input  logic [3:0]       key_code,
    input  logic [7:0]       max_length,
    input  logic [7:0]       commit_ticks,
    output mtk_pkg::state_t  state_next,
    output mtk_pkg::result_t result
);
    import mtk_pkg::*;

    logic       acc;
    logic       wv;
    logic [7:0] widx;
    logic [6:0] wch;
    logic       has_room;
    logic [2:0] pos_inc;
    logic [2:0] pos_next;
    logic [6:0] raw_char;
    logic [6:0] raw_first;
    logic [7:0] ticks_inc;

    assign has_room  = state.length_count < max_length;
    assign pos_inc   = state.cycle_position + 3'd1;
    assign pos_next  = (pos_inc >= key_count(key_code)) ? 3'd0 : pos_inc;
    assign raw_char  = key_char(key_code, pos_next);
    assign raw_first = key_char(key_code, 3'd0);
    assign ticks_inc = (state.idle_ticks != TICKS_SAT) ? state.idle_ticks + 8'd1
                                                      : state.idle_ticks;

    // lower-case fold of letters when not in upper-case mode
    function automatic logic [6:0] fold(input logic [6:0] c, input logic up);
        logic [6:0] r;
        r = c;
        if (!up && c >= 7'h41 && c <= 7'h5A) begin
            r = c + 7'd32;
        end
        return r;
    endfunction

    always_comb begin
        state_next = state;
        acc  = 1'b1;
        wv   = 1'b0;
        widx = 8'd0;
        wch  = 7'd0;

        unique case (func)
            FUNC_PRESS: begin
                priority if (key_code == KEY_MODE) begin
                    state_next.pending_flag   = 1'b0;
                    state_next.tap_key        = 4'd0;
                    state_next.cycle_position = 3'd0;
                    state_next.idle_ticks     = 8'd0;
                    unique case (state.entry_mode)
                        MODE_UPPER:  state_next.entry_mode = MODE_LOWER;
                        MODE_LOWER:  state_next.entry_mode = MODE_DIGITS;
                        MODE_DIGITS: state_next.entry_mode = MODE_UPPER;
                        MODE_SPARE:  state_next.entry_mode = MODE_LOWER;
                        default:     state_next.entry_mode = MODE_UPPER;
                    endcase
                    state_next.upper_flag = (state_next.entry_mode == MODE_UPPER);
                end else if (key_code == KEY_FUNC || key_code == KEY_BACK) begin
                    if (state.length_count != 8'd0) begin
                        state_next.length_count = state.length_count - 8'd1;
                        wv   = 1'b1;
                        widx = state.length_count - 8'd1;
                    end
                    state_next.pending_flag   = 1'b0;
                    state_next.tap_key        = 4'd0;
                    state_next.cycle_position = 3'd0;
                    state_next.idle_ticks     = 8'd0;
                end else if (key_code > KEY_LAST_DIG) begin
                    acc = 1'b0;
                end else if (state.entry_mode == MODE_DIGITS) begin
                    state_next.pending_flag   = 1'b0;
                    state_next.tap_key        = 4'd0;
                    state_next.cycle_position = 3'd0;
                    state_next.idle_ticks     = 8'd0;
                    if (has_room) begin
                        wv   = 1'b1;
                        widx = state.length_count;
                        wch  = CHAR_ZERO + 7'(key_code);
                        state_next.length_count = state.length_count + 8'd1;
                    end
                end else if (state.pending_flag && state.tap_key == key_code
                             && state.length_count != 8'd0) begin
                    // repeat press: replace last character in place
                    state_next.cycle_position = pos_next;
                    state_next.idle_ticks     = 8'd0;
                    wv   = 1'b1;
                    widx = state.length_count - 8'd1;
                    wch  = fold(raw_char, state.upper_flag);
                end else begin
                    state_next.pending_flag   = 1'b0;
                    state_next.tap_key        = 4'd0;
                    state_next.cycle_position = 3'd0;
                    state_next.idle_ticks     = 8'd0;
                    if (has_room) begin
                        state_next.pending_flag = 1'b1;
                        state_next.tap_key      = key_code;
                        wv   = 1'b1;
                        widx = state.length_count;
                        wch  = fold(raw_first, state.upper_flag);
                        state_next.length_count = state.length_count + 8'd1;
                    end
                end
            end
            FUNC_LONG_PRESS: begin
                if (key_code > KEY_LAST_DIG) begin
                    acc = 1'b0;
                end else begin
                    state_next.pending_flag   = 1'b0;
                    state_next.tap_key        = 4'd0;
                    state_next.cycle_position = 3'd0;
                    state_next.idle_ticks     = 8'd0;
                    if (has_room) begin
                        wv   = 1'b1;
                        widx = state.length_count;
                        wch  = CHAR_ZERO + 7'(key_code);
                        state_next.length_count = state.length_count + 8'd1;
                    end
                end
            end
            FUNC_TICK: begin
                if (state.pending_flag) begin
                    if (ticks_inc >= commit_ticks) begin
                        state_next.pending_flag   = 1'b0;
                        state_next.tap_key        = 4'd0;
                        state_next.cycle_position = 3'd0;
                        state_next.idle_ticks     = 8'd0;
                    end else begin
                        state_next.idle_ticks = ticks_inc;
                    end
                end
            end
            FUNC_COMMIT: begin
                state_next.pending_flag   = 1'b0;
                state_next.tap_key        = 4'd0;
                state_next.cycle_position = 3'd0;
                state_next.idle_ticks     = 8'd0;
            end
            FUNC_START: begin
                state_next.length_count   = 8'd0;
                state_next.entry_mode     = MODE_UPPER;
                state_next.upper_flag     = 1'b1;
                state_next.pending_flag   = 1'b0;
                state_next.tap_key        = 4'd0;
                state_next.cycle_position = 3'd0;
                state_next.idle_ticks     = 8'd0;
            end
            default: begin
                acc = 1'b0;
            end
        endcase

        result.accepted       = acc;
        result.write_valid    = wv;
        result.write_index    = widx;
        result.write_char     = wch;
        result.text_length    = state_next.length_count;
        result.entry_mode_out = state_next.entry_mode;
        result.pending_out    = state_next.pending_flag;
    end

endmodule

[tb/multitap_keypad_text_entry_unit_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the multi-tap keypad text entry unit
module multitap_keypad_text_entry_unit_tb;

    import mtk_pkg::*;

    // cycles with no word moving on either side before the run is abandoned
    localparam int QUIET_LIMIT = 2000;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_addr      = CFG_MAX_LENGTH;
    logic [7:0]  cfg_wdata     = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [3:0] key_code, [7:4] zero
    logic [2:0]  s_axis_tuser  = FUNC_PRESS;   // [2:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [31:0] m_axis_tdata;   // [7:0] write_index, [14:8] write_char, [22:15] text_length,
                                 // [24:23] entry_mode_out, [25] pending_out
    logic [1:0]  m_axis_tuser;   // [0] accepted, [1] write_valid

    multitap_keypad_text_entry_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predicted keypad state, kept in step with every accepted event word
    logic [7:0] text_len;
    logic [7:0] text_cap;
    logic [7:0] commit_after;
    logic [1:0] mode_now;
    logic       caps_on;
    logic       cycling;
    logic [3:0] cycling_key;
    logic [2:0] tap_pos;
    logic [7:0] tick_run;

    result_t expected_reports[$];
    result_t oldest_report;
    int      mismatch_count = 0;
    int      words_sent = 0;
    int      quiet_cycles = 0;
    int      sender_gap_pct = 0;
    int      sink_stall_pct = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // characters reached by repeated presses of one digit key, in order
    function automatic string keypad_letters(input logic [3:0] key);
        string row;
        case (key)
            4'd0:    row = " 0";
            4'd1:    row = ".,?!1";
            4'd2:    row = "ABC2";
            4'd3:    row = "DEF3";
            4'd4:    row = "GHI4";
            4'd5:    row = "JKL5";
            4'd6:    row = "MNO6";
            4'd7:    row = "PQRS7";
            4'd8:    row = "TUV8";
            default: row = "WXYZ9";
        endcase
        return row;
    endfunction

    // letters follow the current case, digits and punctuation pass unchanged
    function automatic logic [6:0] fold_case(input byte c);
        if (!caps_on && c >= 8'h41 && c <= 8'h5A)
            c = c + 8'd32;
        return c[6:0];
    endfunction

    function automatic void drop_cycling();
        cycling     = 1'b0;
        cycling_key = 4'd0;
        tap_pos     = 3'd0;
        tick_run    = 8'd0;
    endfunction

    function automatic void restart_text();
        text_len = 8'd0;
        mode_now = MODE_UPPER;
        caps_on  = 1'b1;
        drop_cycling();
    endfunction

    function automatic result_t predict_keypad_event(input logic [2:0] func,
                                                     input logic [3:0] key);
        result_t rep;
        string   row;
        rep = '0;
        rep.accepted = 1'b1;
        row = keypad_letters(key);
        case (func)
            FUNC_PRESS: begin
                if (key == KEY_MODE) begin
                    drop_cycling();
                    // upper -> lower -> digits -> upper; the spare mode lands on lower
                    case (mode_now)
                        MODE_UPPER:  mode_now = MODE_LOWER;
                        MODE_LOWER:  mode_now = MODE_DIGITS;
                        MODE_DIGITS: mode_now = MODE_UPPER;
                        default:     mode_now = MODE_LOWER;
                    endcase
                    caps_on = (mode_now == MODE_UPPER);
                end else if (key == KEY_FUNC || key == KEY_BACK) begin
                    if (text_len != 8'd0) begin
                        text_len = text_len - 8'd1;
                        rep.write_valid = 1'b1;
                        rep.write_index = text_len;
                    end
                    drop_cycling();
                end else if (key > KEY_LAST_DIG) begin
                    rep.accepted = 1'b0;
                end else if (mode_now == MODE_DIGITS) begin
                    drop_cycling();
                    if (text_len < text_cap) begin
                        rep.write_valid = 1'b1;
                        rep.write_index = text_len;
                        rep.write_char  = CHAR_ZERO + 7'(key);
                        text_len = text_len + 8'd1;
                    end
                end else if (cycling && cycling_key == key && text_len != 8'd0) begin
                    // repeat press: overwrite the last character with the next one
                    tap_pos = 3'((int'(tap_pos) + 1) % row.len());
                    rep.write_valid = 1'b1;
                    rep.write_index = text_len - 8'd1;
                    rep.write_char  = fold_case(row[tap_pos]);
                    tick_run = 8'd0;
                end else begin
                    drop_cycling();
                    if (text_len < text_cap) begin
                        cycling     = 1'b1;
                        cycling_key = key;
                        rep.write_valid = 1'b1;
                        rep.write_index = text_len;
                        rep.write_char  = fold_case(row[0]);
                        text_len = text_len + 8'd1;
                    end
                end
            end
            FUNC_LONG_PRESS: begin
                if (key > KEY_LAST_DIG) begin
                    rep.accepted = 1'b0;
                end else begin
                    drop_cycling();
                    if (text_len < text_cap) begin
                        rep.write_valid = 1'b1;
                        rep.write_index = text_len;
                        rep.write_char  = CHAR_ZERO + 7'(key);
                        text_len = text_len + 8'd1;
                    end
                end
            end
            FUNC_TICK: begin
                if (cycling) begin
                    if (tick_run != TICKS_SAT)
                        tick_run = tick_run + 8'd1;
                    if (tick_run >= commit_after)
                        drop_cycling();
                end
            end
            FUNC_COMMIT: drop_cycling();
            FUNC_START:  restart_text();
            default:     rep.accepted = 1'b0;
        endcase
        rep.text_length    = text_len;
        rep.entry_mode_out = mode_now;
        rep.pending_out    = cycling;
        return rep;
    endfunction

    // ---------------------------------------------------------------
    // result checking: every result word against the oldest prediction
    // ---------------------------------------------------------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_reports.size() == 0) begin
                $error("result word with nothing predicted: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                oldest_report = expected_reports.pop_front();
                check_field("accepted", oldest_report.accepted, m_axis_tuser[0]);
                check_field("write_valid", oldest_report.write_valid, m_axis_tuser[1]);
                check_field("write_index", oldest_report.write_index, m_axis_tdata[7:0]);
                check_field("write_char", oldest_report.write_char, m_axis_tdata[14:8]);
                check_field("text_length", oldest_report.text_length, m_axis_tdata[22:15]);
                check_field("entry_mode_out", oldest_report.entry_mode_out,
                            m_axis_tdata[24:23]);
                check_field("pending_out", oldest_report.pending_out, m_axis_tdata[25]);
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge aclk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // watchdog: a stuck handshake on either side ends the run
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // one event word; valid stays high into the next word unless a gap is drawn
    task automatic send_word(input logic [2:0] func, input logic [3:0] key);
        if ($urandom_range(0, 99) < sender_gap_pct) begin
            @(negedge aclk) s_axis_tvalid <= 1'b0;
            while ($urandom_range(0, 99) < sender_gap_pct)
                @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {4'b0000, key};
        do @(posedge aclk); while (!s_axis_tready);
        expected_reports.push_back(predict_keypad_event(func, key));
        words_sent++;
    endtask

    // stop sending and let every predicted result come out
    task automatic drain_results();
        @(negedge aclk) s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge aclk);
        // margin after the last result is checked
        repeat (3) @(posedge aclk);
    endtask

    // only called with the unit drained
    task automatic write_register(input logic addr, input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk) cfg_wr_en <= 1'b0;
        if (addr == CFG_MAX_LENGTH)
            text_cap = value;
        else
            commit_after = value;
    endtask

    task automatic set_idling(input int gap_pct, input int stall_pct);
        sender_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
    endtask

    // one short sequence: mostly multi-tap runs with their ticks, some edits and noise
    task automatic random_keypad_burst();
        int pick;
        int presses;
        int ticks;
        int tick_cap;
        logic [3:0] key;
        pick = $urandom_range(0, 99);
        key  = 4'($urandom_range(0, 9));
        tick_cap = (commit_after > 8'd8) ? 8 : int'(commit_after) + 1;
        if (pick < 45) begin
            presses = $urandom_range(1, 6);
            repeat (presses) send_word(FUNC_PRESS, key);
            ticks = $urandom_range(0, tick_cap);
            repeat (ticks) send_word(FUNC_TICK, 4'($urandom_range(0, 15)));
        end else if (pick < 55) begin
            send_word(FUNC_PRESS, KEY_MODE);
        end else if (pick < 65) begin
            send_word(FUNC_PRESS, ($urandom_range(0, 1) != 0) ? KEY_FUNC : KEY_BACK);
        end else if (pick < 75) begin
            send_word(FUNC_LONG_PRESS, key);
        end else if (pick < 80) begin
            send_word(FUNC_COMMIT, 4'($urandom_range(0, 15)));
        end else if (pick < 83) begin
            send_word(FUNC_START, 4'($urandom_range(0, 15)));
        end else if (pick < 88) begin
            send_word(FUNC_TICK, 4'($urandom_range(0, 15)));
        end else begin
            // noise: unknown kinds, keys without a meaning, or anything at all
            case ($urandom_range(0, 3))
                0:       send_word(3'($urandom_range(5, 7)), 4'($urandom_range(0, 15)));
                1:       send_word(FUNC_PRESS, 4'($urandom_range(13, 15)));
                2:       send_word(FUNC_LONG_PRESS, 4'($urandom_range(10, 15)));
                default: send_word(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset configuration: cycling, case modes, deletes, ignored words
    task automatic test_basic_entry();
        repeat (5) send_word(FUNC_PRESS, 4'd2);     // A B C 2 and wrap to A
        send_word(FUNC_PRESS, 4'd3);                // other key starts a new character
        send_word(FUNC_PRESS, 4'd0);
        send_word(FUNC_PRESS, 4'd0);
        send_word(FUNC_PRESS, KEY_MODE);            // lower case
        send_word(FUNC_PRESS, 4'd7);
        send_word(FUNC_PRESS, 4'd1);
        send_word(FUNC_LONG_PRESS, 4'd9);
        send_word(FUNC_LONG_PRESS, KEY_MODE);       // long press of a non-digit is ignored
        send_word(FUNC_PRESS, 4'd15);               // unknown key is rejected, state unchanged
        send_word(FUNC_PRESS, KEY_MODE);            // digits
        send_word(FUNC_PRESS, 4'd5);
        send_word(FUNC_PRESS, KEY_MODE);            // back to upper case
        send_word(FUNC_PRESS, KEY_FUNC);
        send_word(FUNC_PRESS, KEY_BACK);
        send_word(3'd5, 4'd1);
        send_word(3'd7, 4'd14);
        send_word(FUNC_COMMIT, 4'd0);
        send_word(FUNC_TICK, 4'd0);
        send_word(FUNC_START, 4'd0);
        send_word(FUNC_PRESS, KEY_FUNC);            // delete on empty text
    endtask

    // tiny capacity, commit on first tick, zero capacity
    task automatic test_full_text();
        drain_results();
        write_register(CFG_MAX_LENGTH, 8'd2);
        write_register(CFG_COMMIT_TICKS, 8'd0);
        send_word(FUNC_PRESS, 4'd4);
        send_word(FUNC_TICK, 4'd0);                 // commits at once
        send_word(FUNC_PRESS, 4'd4);                // new character, text now full
        send_word(FUNC_PRESS, 4'd5);                // dropped but accepted
        send_word(FUNC_LONG_PRESS, 4'd3);
        repeat (2) send_word(FUNC_PRESS, KEY_MODE);
        send_word(FUNC_PRESS, 4'd8);                // digit append dropped too
        repeat (3) send_word(FUNC_PRESS, KEY_BACK);
        drain_results();
        write_register(CFG_MAX_LENGTH, 8'd0);
        send_word(FUNC_PRESS, 4'd2);
        send_word(FUNC_LONG_PRESS, 4'd0);
    endtask

    // largest settings: slowest commit and a text filled to the last position
    task automatic test_long_text();
        drain_results();
        set_idling(7, 7);
        write_register(CFG_MAX_LENGTH, 8'd255);
        write_register(CFG_COMMIT_TICKS, 8'd255);
        send_word(FUNC_START, 4'd0);
        send_word(FUNC_PRESS, 4'd8);
        // still pending after 254 ticks, committed on the 255th
        repeat (255) send_word(FUNC_TICK, 4'($urandom_range(0, 15)));
        repeat (256) send_word(FUNC_LONG_PRESS, 4'($urandom_range(0, 9)));
        send_word(FUNC_PRESS, KEY_FUNC);
        send_word(FUNC_PRESS, KEY_BACK);
    endtask

    // random sequences under each idling pattern and several settings
    task automatic test_random_traffic();
        int phase_start;
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    set_idling(0, 0);
                    write_register(CFG_MAX_LENGTH, 8'd12);
                    write_register(CFG_COMMIT_TICKS, 8'd3);
                end
                1: begin
                    set_idling(48, 0);
                    write_register(CFG_MAX_LENGTH, 8'd40);
                    write_register(CFG_COMMIT_TICKS, 8'd1);
                end
                2: begin
                    set_idling(0, 48);
                    write_register(CFG_MAX_LENGTH, 8'($urandom_range(1, 20)));
                    write_register(CFG_COMMIT_TICKS, 8'($urandom_range(1, 6)));
                end
                default: begin
                    set_idling(7, 7);
                    write_register(CFG_MAX_LENGTH, 8'd6);
                    write_register(CFG_COMMIT_TICKS, 8'd2);
                end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < 25)
                random_keypad_burst();
        end
    endtask

    // ---------------------------------------------------------------
    // sequence of tests
    // ---------------------------------------------------------------

    initial begin
        text_cap     = MAX_LENGTH_RST;
        commit_after = COMMIT_TICKS_RST;
        restart_text();
        // synchronous reset held, then released on a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_basic_entry();
        test_full_text();
        test_long_text();
        test_random_traffic();

        drain_results();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
